// ===== hdl/rti_pkg.sv =====
package rti_pkg;

  // Coordinate format: signed, CoordW bits, FracBits fraction bits.
  localparam int CoordW   = 32;
  localparam int FracBits = 16;
  localparam int TagW     = 24;
  localparam int DistW    = CoordW - 1;
  localparam int BaryW    = FracBits + 1;

  // Config register file
  localparam int CfgDataW = 32;
  localparam int AddrW    = 5;

  // Intermediate widths
  localparam int EW   = CoordW + 1;        // edge and origin-offset vectors
  localparam int PW   = EW + CoordW + 1;   // P = D x e2
  localparam int QW   = 2 * EW + 1;        // Q = T x e1
  localparam int SumW = EW + QW + 2;       // det, un, vn, tn

  // Near-parallel threshold, round(1e-6 * 2^(3*FracBits)) in det format
  localparam logic [SumW-1:0] Eps =
      SumW'(((128'd1 << (3 * FracBits)) + 128'd500000) / 128'd1000000);

  typedef enum logic [2:0] {
    RegOriginX = 3'd0,
    RegOriginY = 3'd1,
    RegOriginZ = 3'd2,
    RegDirX    = 3'd3,
    RegDirY    = 3'd4,
    RegDirZ    = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] az;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
    logic signed [CoordW-1:0] bz;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cz;
    logic [TagW-1:0]          tri_tag;
  } tri_item_t;

  typedef struct packed {
    logic             hit;
    logic [DistW-1:0] distance;
    logic [BaryW-1:0] bary_u;
    logic [BaryW-1:0] bary_v;
    logic [TagW-1:0]  tag_out;
  } isect_result_t;

endpackage

// ===== hdl/rti_mul.sv =====
// Signed multiplier, A narrow, B cut into 32-bit chunks. Partial products are
// registered, then summed and registered.
module rti_mul #(
  parameter int AW = 33,
  parameter int BW = 66
) (
  input  logic                    clk_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [BW-1:0]    b_i,
  output logic signed [AW+BW-1:0] p_o
);

  localparam int NC = (BW + 31) / 32;
  localparam int XW = NC * 32;
  localparam int MW = AW + 33;
  localparam int SW = AW + XW + 1;

  logic signed [XW-1:0]    b_x;
  logic signed [MW-1:0]    a_ext;
  logic signed [MW-1:0]    c_ext [NC];
  logic signed [MW-1:0]    part_d [NC];
  logic signed [MW-1:0]    part_q [NC];
  logic signed [SW-1:0]    acc;
  logic signed [AW+BW-1:0] p_q;

  assign b_x   = XW'(b_i);
  assign a_ext = MW'(a_i);

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      if (k == NC - 1) begin
        c_ext[k] = MW'($signed(b_x[k*32 +: 32]));
      end else begin
        c_ext[k] = MW'($signed({1'b0, b_x[k*32 +: 32]}));
      end
      part_d[k] = a_ext * c_ext[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NC; k++) begin
      part_q[k] <= part_d[k];
    end
  end

  always_comb begin
    acc = '0;
    for (int k = 0; k < NC; k++) begin
      acc = acc + (SW'(part_q[k]) <<< (32 * k));
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= acc[AW+BW-1:0];
  end

  assign p_o = p_q;

endmodule

// ===== hdl/rti_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Requires num_i < den_i << QB.
module rti_div #(
  parameter int NW = 118,
  parameter int DW = 102,
  parameter int QB = 31,
  parameter int SW = 26
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [SW-1:0] side_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          valid_o,
  output logic [SW-1:0] side_o,
  output logic [QB-1:0] quo_o
);

  localparam int RW = DW + 1;

  logic          valid_q [QB+1];
  logic [SW-1:0] side_q  [QB+1];
  logic [RW-1:0] rem_q   [QB+1];
  logic [QB-1:0] low_q   [QB+1];
  logic [QB-1:0] quo_q   [QB+1];
  logic [DW-1:0] den_q   [QB+1];
  logic [RW-1:0] trial   [QB];
  logic          take    [QB];

  always_comb begin
    for (int k = 0; k < QB; k++) begin
      trial[k] = {rem_q[k][RW-2:0], low_q[k][QB-1]};
      take[k]  = trial[k] >= RW'(den_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QB; k++) begin
        valid_q[k] <= 1'b0;
      end
    end else begin
      valid_q[0] <= valid_i;
      for (int k = 1; k <= QB; k++) begin
        valid_q[k] <= valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_i;
    rem_q[0]  <= RW'(num_i[NW-1:QB]);
    low_q[0]  <= num_i[QB-1:0];
    quo_q[0]  <= '0;
    den_q[0]  <= den_i;
    for (int k = 1; k <= QB; k++) begin
      side_q[k] <= side_q[k-1];
      den_q[k]  <= den_q[k-1];
      low_q[k]  <= low_q[k-1] << 1;
      quo_q[k]  <= {quo_q[k-1][QB-2:0], take[k-1]};
      rem_q[k]  <= take[k-1] ? (trial[k-1] - RW'(den_q[k-1])) : trial[k-1];
    end
  end

  assign valid_o = valid_q[QB];
  assign side_o  = side_q[QB];
  assign quo_o   = quo_q[QB];

endmodule

// ===== hdl/ray_triangle_intersect.sv =====
// A result strobes done_o after the start transfer has passed through the
//   9 arithmetic stages, a 32-stage divider (input register, then one quotient bit per stage) and the output register.
// Throughput: one triangle per cycle; busy is never raised and results cannot be stalled.
// Reset (rst_ni low, asynchronous): pipeline valids cleared, ray registers cleared to zero,
//   so every triangle misses until a direction is written.
module ray_triangle_intersect (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // command channel
  input  logic                   start,
  output logic                   busy,
  input  rti_pkg::tri_item_t     item_i,
  // result channel
  output logic                   done_o,
  output rti_pkg::isect_result_t result_o,
  // APB config port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [rti_pkg::AddrW-1:0]    paddr,
  input  logic [rti_pkg::CfgDataW-1:0] pwdata,
  output logic [rti_pkg::CfgDataW-1:0] prdata,
  output logic                   pready
);

  import rti_pkg::*;

  localparam int Sh      = DistW - FracBits;   // saturation test shift
  localparam int NW      = SumW + FracBits;
  localparam int SideW   = TagW + 2;
  localparam int Latency = 11 + DistW;

  // ---------------------------------------------------------------------------
  // Ray registers (APB). pready is tied high; writes land on the access phase.
  // ---------------------------------------------------------------------------
  logic signed [CoordW-1:0] org_q [3];
  logic signed [CoordW-1:0] dir_q [3];
  logic                     cfg_wr;
  reg_idx_e                 cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        org_q[i] <= '0;
        dir_q[i] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegOriginX: org_q[0] <= pwdata;
        RegOriginY: org_q[1] <= pwdata;
        RegOriginZ: org_q[2] <= pwdata;
        RegDirX:    dir_q[0] <= pwdata;
        RegDirY:    dir_q[1] <= pwdata;
        RegDirZ:    dir_q[2] <= pwdata;
        default: ;   // unmapped slots ignore writes
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegOriginX: prdata = org_q[0];
      RegOriginY: prdata = org_q[1];
      RegOriginZ: prdata = org_q[2];
      RegDirX:    prdata = dir_q[0];
      RegDirY:    prdata = dir_q[1];
      RegDirZ:    prdata = dir_q[2];
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: the datapath never stalls, so valid and tag just shift.
  // ---------------------------------------------------------------------------
  logic            accept;
  logic            v_q   [1:9];
  logic [TagW-1:0] tag_q [1:9];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= 9; k++) begin
        v_q[k] <= 1'b0;
      end
    end else begin
      v_q[1] <= accept;
      for (int k = 2; k <= 9; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q[1] <= item_i.tri_tag;
    for (int k = 2; k <= 9; k++) begin
      tag_q[k] <= tag_q[k-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: edges e1 = B-A, e2 = C-A and T = O-A (one extra bit, exact)
  // ---------------------------------------------------------------------------
  logic signed [CoordW-1:0] va [3];
  logic signed [CoordW-1:0] vb [3];
  logic signed [CoordW-1:0] vc [3];
  logic signed [EW-1:0]     e1_s1 [3], e2_s1 [3], t_s1 [3];
  logic signed [EW-1:0]     e1_s2 [3], e2_s2 [3], t_s2 [3];
  logic signed [EW-1:0]     e1_s3 [3], e2_s3 [3], t_s3 [3];
  logic signed [EW-1:0]     e1_s4 [3], e2_s4 [3], t_s4 [3];

  always_comb begin
    va[0] = item_i.ax; va[1] = item_i.ay; va[2] = item_i.az;
    vb[0] = item_i.bx; vb[1] = item_i.by; vb[2] = item_i.bz;
    vc[0] = item_i.cx; vc[1] = item_i.cy; vc[2] = item_i.cz;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      e1_s1[i] <= EW'(vb[i]) - EW'(va[i]);
      e2_s1[i] <= EW'(vc[i]) - EW'(va[i]);
      t_s1[i]  <= EW'(org_q[i]) - EW'(va[i]);
      // hold the vectors alongside the cross-product multipliers
      e1_s2[i] <= e1_s1[i]; e2_s2[i] <= e2_s1[i]; t_s2[i] <= t_s1[i];
      e1_s3[i] <= e1_s2[i]; e2_s3[i] <= e2_s2[i]; t_s3[i] <= t_s2[i];
      e1_s4[i] <= e1_s3[i]; e2_s4[i] <= e2_s3[i]; t_s4[i] <= t_s3[i];
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 2-4: P = D x e2 and Q = T x e1. The multipliers fill stages 2 and 3,
  // the difference is registered in stage 4.
  // ---------------------------------------------------------------------------
  logic signed [EW+CoordW-1:0] pm_a [3], pm_b [3];
  logic signed [2*EW-1:0]      qm_a [3], qm_b [3];
  logic signed [PW-1:0]        p_s4 [3];
  logic signed [QW-1:0]        q_s4 [3];

  for (genvar i = 0; i < 3; i++) begin : g_cross
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    rti_mul #(.AW(EW), .BW(CoordW)) u_pa (
      .clk_i, .a_i(e2_s1[K]), .b_i(dir_q[J]), .p_o(pm_a[i])
    );
    rti_mul #(.AW(EW), .BW(CoordW)) u_pb (
      .clk_i, .a_i(e2_s1[J]), .b_i(dir_q[K]), .p_o(pm_b[i])
    );
    rti_mul #(.AW(EW), .BW(EW)) u_qa (
      .clk_i, .a_i(t_s1[J]), .b_i(e1_s1[K]), .p_o(qm_a[i])
    );
    rti_mul #(.AW(EW), .BW(EW)) u_qb (
      .clk_i, .a_i(t_s1[K]), .b_i(e1_s1[J]), .p_o(qm_b[i])
    );

    always_ff @(posedge clk_i) begin
      p_s4[i] <= PW'(pm_a[i]) - PW'(pm_b[i]);
      q_s4[i] <= QW'(qm_a[i]) - QW'(qm_b[i]);
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 5-7: det = e1.P, un = T.P, vn = D.Q, tn = e2.Q, exact.
  // ---------------------------------------------------------------------------
  logic signed [EW+PW-1:0]     dm [3];
  logic signed [EW+PW-1:0]     um [3];
  logic signed [CoordW+QW-1:0] vm [3];
  logic signed [EW+QW-1:0]     tm [3];
  logic signed [SumW-1:0]      det_s7, un_s7, vn_s7, tn_s7;

  for (genvar i = 0; i < 3; i++) begin : g_dot
    rti_mul #(.AW(EW), .BW(PW)) u_det (
      .clk_i, .a_i(e1_s4[i]), .b_i(p_s4[i]), .p_o(dm[i])
    );
    rti_mul #(.AW(EW), .BW(PW)) u_un (
      .clk_i, .a_i(t_s4[i]), .b_i(p_s4[i]), .p_o(um[i])
    );
    rti_mul #(.AW(CoordW), .BW(QW)) u_vn (
      .clk_i, .a_i(dir_q[i]), .b_i(q_s4[i]), .p_o(vm[i])
    );
    rti_mul #(.AW(EW), .BW(QW)) u_tn (
      .clk_i, .a_i(e2_s4[i]), .b_i(q_s4[i]), .p_o(tm[i])
    );
  end

  always_ff @(posedge clk_i) begin
    det_s7 <= SumW'(dm[0]) + SumW'(dm[1]) + SumW'(dm[2]);
    un_s7  <= SumW'(um[0]) + SumW'(um[1]) + SumW'(um[2]);
    vn_s7  <= SumW'(vm[0]) + SumW'(vm[1]) + SumW'(vm[2]);
    tn_s7  <= SumW'(tm[0]) + SumW'(tm[1]) + SumW'(tm[2]);
  end

  // ---------------------------------------------------------------------------
  // Stage 8: fold the sign of det into all four terms.
  // ---------------------------------------------------------------------------
  logic                   flip;
  logic [SumW-1:0]        adet_s8;
  logic signed [SumW-1:0] un_s8, vn_s8, tn_s8;

  assign flip = det_s7[SumW-1];

  always_ff @(posedge clk_i) begin
    adet_s8 <= flip ? -det_s7 : det_s7;
    un_s8   <= flip ? -un_s7  : un_s7;
    vn_s8   <= flip ? -vn_s7  : vn_s7;
    tn_s8   <= flip ? -tn_s7  : tn_s7;
  end

  // ---------------------------------------------------------------------------
  // Stage 9: acceptance tests on exact ratios, distance saturation test,
  // divider operands. Misses feed zero numerators to all three dividers and saturated
  // distances a zero t numerator, so the divider precondition holds on every hit.
  // ---------------------------------------------------------------------------
  logic [SumW:0]    uv_sum;
  logic             hit_d, sat_d;
  logic             hit_s9, sat_s9;
  logic [NW-1:0]    nu_s9, nv_s9, nt_s9;
  logic [SumW-1:0]  den_s9;

  always_comb begin
    uv_sum = {1'b0, un_s8} + {1'b0, vn_s8};
    hit_d  = (adet_s8 >= Eps) && !un_s8[SumW-1] && !vn_s8[SumW-1] &&
             !tn_s8[SumW-1] && (uv_sum <= {1'b0, adet_s8});
    sat_d  = {{Sh{1'b0}}, tn_s8} >= {adet_s8, {Sh{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    hit_s9 <= hit_d;
    sat_s9 <= sat_d;
    den_s9 <= adet_s8;
    nu_s9  <= hit_d ? {un_s8, {FracBits{1'b0}}} : '0;
    nv_s9  <= hit_d ? {vn_s8, {FracBits{1'b0}}} : '0;
    nt_s9  <= (hit_d && !sat_d) ? {tn_s8, {FracBits{1'b0}}} : '0;
  end

  // ---------------------------------------------------------------------------
  // Dividers: t, u and v in lockstep; the t lane carries hit, sat and tag.
  // ---------------------------------------------------------------------------
  logic             dv_valid;
  logic [SideW-1:0] dv_side;
  logic [DistW-1:0] quo_t, quo_u, quo_v;

  rti_div #(.NW(NW), .DW(SumW), .QB(DistW), .SW(SideW)) u_div_t (
    .clk_i, .rst_ni,
    .valid_i(v_q[9]), .side_i({hit_s9, sat_s9, tag_q[9]}),
    .num_i(nt_s9), .den_i(den_s9),
    .valid_o(dv_valid), .side_o(dv_side), .quo_o(quo_t)
  );

  rti_div #(.NW(NW), .DW(SumW), .QB(DistW), .SW(SideW)) u_div_u (
    .clk_i, .rst_ni,
    .valid_i(v_q[9]), .side_i('0),
    .num_i(nu_s9), .den_i(den_s9),
    .valid_o(), .side_o(), .quo_o(quo_u)
  );

  rti_div #(.NW(NW), .DW(SumW), .QB(DistW), .SW(SideW)) u_div_v (
    .clk_i, .rst_ni,
    .valid_i(v_q[9]), .side_i('0),
    .num_i(nv_s9), .den_i(den_s9),
    .valid_o(), .side_o(), .quo_o(quo_v)
  );

  // ---------------------------------------------------------------------------
  // Output register: one-cycle strobe, distance and barycentrics zeroed on a miss.
  // ---------------------------------------------------------------------------
  logic          dv_hit, dv_sat;
  logic          done_q;
  isect_result_t res_d, res_q;

  assign dv_hit = dv_side[SideW-1];
  assign dv_sat = dv_side[SideW-2];

  always_comb begin
    res_d.hit      = dv_hit;
    res_d.distance = dv_hit ? (dv_sat ? {DistW{1'b1}} : quo_t) : '0;
    res_d.bary_u   = dv_hit ? quo_u[BaryW-1:0] : '0;
    res_d.bary_v   = dv_hit ? quo_v[BaryW-1:0] : '0;
    res_d.tag_out  = dv_side[TagW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_fixed_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency done_o)
    else $error("result missing at fixed latency");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, Latency))
    else $error("result without matching transfer");

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !result_o.hit |->
      result_o.distance == '0 && result_o.bary_u == '0 && result_o.bary_v == '0)
    else $error("miss result carries nonzero fields");

  a_bary_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.hit |->
      ({1'b0, result_o.bary_u} + {1'b0, result_o.bary_v}) <= (BaryW + 1)'(1 << FracBits))
    else $error("barycentric sum exceeds one");

endmodule
